/* rtl/vurp_pkg.sv */
// Package for the video unit register port: word types, action and register codes.
// Used by the top level and the port checker; depends on nothing.
package vurp_pkg;

    localparam int NtDepth   = 2048;
    localparam int PalDepth  = 32;
    localparam int SprDepth  = 256;
    localparam int PatDepth  = 8192;

    // Action codes
    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_TICK  = 3'd2;
    localparam logic [2:0] ACT_PLOAD = 3'd3;
    localparam logic [2:0] ACT_DMA   = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPADDR = 3'd3;
    localparam logic [2:0] REG_SPDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    // Counter limits
    localparam logic [9:0] DotsPerLine = 10'd341;
    localparam logic [8:0] LineVblank  = 9'd241;
    localparam logic [8:0] LinePre     = 9'd261;
    localparam logic [8:0] LineRender  = 9'd240;
    localparam logic [8:0] NmiDots     = 9'd21;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  register_index;
        logic [7:0]  write_data;
        logic [7:0]  dot_count;
        logic [12:0] load_address;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_pulse;
        logic       access_fault;
        logic [8:0] line_now;
        logic [8:0] dot_now;
    } t_out_word;

endpackage

/* rtl/vurp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vurp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/video_unit_register_port_top.sv */
// Top level of the video unit register port: registers, counters, memories.
// Depends on vurp_pkg and vurp_ram.
//
// Usage
//   Input channel (i_in_valid / o_in_stall, word i_in_word) carries one action:
//   register write or read, dot tick, pattern load or sprite DMA byte.
//   Output channel (o_out_valid / i_out_stall, word o_out_word) returns one
//   result word per input word, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the mirroring
//   mode bit; it is always ready. Write it only while the block is idle.
//   Each word passes through the idle state, which presents the memory read addresses (taken
//   from the held address registers), and the execute state, which uses the read data,
//   writes back and loads the output register, since the memory read data is registered.
//   A new word is taken while an earlier result waits in the output register;
//   when the receiver stalls, the execute cycle holds until the register frees.
//   After reset a clearing pass zeroes nametable, palette and sprite memory,
//   stepping through every nametable address while o_in_stall is high.
module video_unit_register_port_top
    import vurp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [10:0] r_clr_cnt;
    t_in_word    r_item;
    logic        r_mirror;
    logic [15:0] r_vram, n_vram;
    logic [7:0]  r_rdbuf, n_rdbuf;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_spr_addr, n_spr_addr;
    logic [8:0]  r_dot, n_dot;
    logic [8:0]  r_line, n_line;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word, n_out_word;

    logic        w_accept, w_go;
    logic [10:0] w_nt_idx;
    logic [7:0]  w_nt_rd, w_pal_rd, w_spr_rd, w_pat_rd;
    logic        w_nt_we, w_pal_we, w_spr_we, w_pat_we;
    logic [10:0] w_nt_waddr;
    logic [4:0]  w_pal_waddr;
    logic [7:0]  w_spr_waddr;
    logic [7:0]  w_nt_wdata, w_pal_wdata, w_spr_wdata;
    logic [15:0] w_step;
    logic        w_render;
    logic [9:0]  w_dot_sum;
    logic [9:0]  w_dot_wrap;
    logic [8:0]  w_line_inc;
    logic [7:0]  w_rd;
    logic        w_nmi, w_fault;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_go        = (r_state == S_EXEC) && !(r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Nametable index after mirroring; palette mirror shares the same low bits
    assign w_nt_idx = r_mirror ? r_vram[10:0] : {r_vram[11], r_vram[9:0]};
    assign w_step   = r_ctrl[2] ? 16'd32 : 16'd1;
    assign w_render = ((r_line < LineRender) || (r_line == LinePre)) && (r_mask[4:3] != 2'b00);

    // Tick arithmetic: at most one line wrap per tick
    assign w_dot_sum  = {1'b0, r_dot} + {2'b00, r_item.dot_count};
    assign w_dot_wrap = w_dot_sum - DotsPerLine;
    assign w_line_inc = r_line + 9'd1;

    // Memories
    vurp_ram #(.WIDTH(8), .DEPTH(NtDepth)) u_nt_ram (
        .i_clk(i_clk), .i_we(w_nt_we), .i_waddr(w_nt_waddr), .i_wdata(w_nt_wdata),
        .i_raddr(w_nt_idx), .o_rdata(w_nt_rd)
    );
    vurp_ram #(.WIDTH(8), .DEPTH(PalDepth)) u_pal_ram (
        .i_clk(i_clk), .i_we(w_pal_we), .i_waddr(w_pal_waddr), .i_wdata(w_pal_wdata),
        .i_raddr(r_vram[4:0]), .o_rdata(w_pal_rd)
    );
    vurp_ram #(.WIDTH(8), .DEPTH(SprDepth)) u_spr_ram (
        .i_clk(i_clk), .i_we(w_spr_we), .i_waddr(w_spr_waddr), .i_wdata(w_spr_wdata),
        .i_raddr(r_spr_addr), .o_rdata(w_spr_rd)
    );
    vurp_ram #(.WIDTH(8), .DEPTH(PatDepth)) u_pat_ram (
        .i_clk(i_clk), .i_we(w_pat_we), .i_waddr(r_item.load_address),
        .i_wdata(r_item.write_data), .i_raddr(r_vram[12:0]), .o_rdata(w_pat_rd)
    );

    // Memory write ports: clearing pass or execute cycle
    always_comb begin
        w_nt_we     = 1'b0;
        w_pal_we    = 1'b0;
        w_spr_we    = 1'b0;
        w_pat_we    = 1'b0;
        w_nt_waddr  = w_nt_idx;
        w_pal_waddr = r_vram[4:0];
        w_spr_waddr = r_spr_addr;
        w_nt_wdata  = r_item.write_data;
        w_pal_wdata = r_item.write_data;
        w_spr_wdata = r_item.write_data;
        if (r_state == S_CLEAR) begin
            w_nt_we     = 1'b1;
            w_pal_we    = 1'b1;
            w_spr_we    = 1'b1;
            w_nt_waddr  = r_clr_cnt;
            w_pal_waddr = r_clr_cnt[4:0];
            w_spr_waddr = r_clr_cnt[7:0];
            w_nt_wdata  = '0;
            w_pal_wdata = '0;
            w_spr_wdata = '0;
        end else if (w_go) begin
            case (r_item.action)
                ACT_WRITE: begin
                    if (r_item.register_index == REG_SPDATA) begin
                        w_spr_we = !w_render;
                    end else if (r_item.register_index == REG_DATA) begin
                        w_nt_we  = (r_vram >= 16'h2000) && (r_vram <= 16'h3EFF);
                        w_pal_we = (r_vram >= 16'h3F00) && (r_vram <= 16'h3FFF);
                    end
                end
                ACT_PLOAD: w_pat_we = 1'b1;
                ACT_DMA: begin
                    w_spr_we    = 1'b1;
                    w_spr_waddr = r_item.load_address[7:0];
                end
                default: ;
            endcase
        end
    end

    // Execute: register updates and result
    always_comb begin
        n_vram     = r_vram;
        n_rdbuf    = r_rdbuf;
        n_toggle   = r_toggle;
        n_ctrl     = r_ctrl;
        n_mask     = r_mask;
        n_status   = r_status;
        n_spr_addr = r_spr_addr;
        n_dot      = r_dot;
        n_line     = r_line;
        w_rd       = 8'd0;
        w_nmi      = 1'b0;
        w_fault    = 1'b0;
        case (r_item.action)
            ACT_WRITE: begin
                case (r_item.register_index)
                    REG_CTRL: begin
                        n_ctrl = r_item.write_data;
                        w_nmi  = !r_ctrl[7] && r_item.write_data[7] && r_status[7];
                    end
                    REG_MASK:   n_mask = r_item.write_data;
                    REG_SPADDR: n_spr_addr = r_item.write_data;
                    REG_SPDATA: n_spr_addr = r_spr_addr + (w_render ? 8'd4 : 8'd1);
                    REG_SCROLL: n_toggle = !r_toggle;
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_vram = {2'b00, r_item.write_data[5:0], 8'h00};
                        end else begin
                            n_vram = r_vram | {8'h00, r_item.write_data};
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_DATA: begin
                        w_fault = (r_vram < 16'h2000);
                        n_vram  = r_vram + w_step;
                    end
                    default: ;
                endcase
            end
            ACT_READ: begin
                case (r_item.register_index)
                    REG_STATUS: begin
                        n_toggle = 1'b0;
                        w_rd     = r_status;
                        n_status = {1'b0, r_status[6:0]};
                    end
                    REG_SPDATA: w_rd = w_spr_rd;
                    REG_DATA: begin
                        w_rd = r_rdbuf;
                        if (r_vram <= 16'h1FFF) begin
                            n_rdbuf = w_pat_rd;
                        end else if (r_vram <= 16'h3EFF) begin
                            n_rdbuf = w_nt_rd;
                        end else if (r_vram <= 16'h3FFF) begin
                            w_rd    = w_pal_rd;
                            n_rdbuf = w_nt_rd;
                        end else begin
                            w_fault = 1'b1;
                        end
                        n_vram = r_vram + w_step;
                    end
                    default: ;
                endcase
            end
            ACT_TICK: begin
                n_dot = w_dot_sum[8:0];
                if (((r_line == LinePre) || (r_line < LineVblank))
                    && (w_dot_sum > 10'd256) && (w_dot_sum < 10'd321)) begin
                    n_spr_addr = 8'd0;
                end
                if (w_dot_sum >= DotsPerLine) begin
                    n_dot  = w_dot_wrap[8:0];
                    n_line = w_line_inc;
                    if (w_line_inc == LineVblank) begin
                        n_status[7] = 1'b1;
                        if (r_ctrl[7]) begin
                            w_nmi = 1'b1;
                            n_dot = w_dot_wrap[8:0] + NmiDots;
                        end
                    end
                    if (w_line_inc == LinePre) begin
                        n_status[6] = 1'b0;
                    end
                    if (w_line_inc > LinePre) begin
                        n_line      = 9'd0;
                        n_status[7] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_cnt == 11'(NtDepth - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  if (w_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        if (w_go) begin
            n_out_valid             = 1'b1;
            n_out_word.read_data    = w_rd;
            n_out_word.nmi_pulse    = w_nmi;
            n_out_word.access_fault = w_fault;
            n_out_word.line_now     = n_line;
            n_out_word.dot_now      = n_dot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_mirror    <= 1'b0;
            r_vram      <= '0;
            r_rdbuf     <= '0;
            r_toggle    <= 1'b0;
            r_ctrl      <= '0;
            r_mask      <= '0;
            r_status    <= '0;
            r_spr_addr  <= '0;
            r_dot       <= '0;
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 11'd1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mirror <= i_cfg_data;
            end
            if (w_go) begin
                r_vram     <= n_vram;
                r_rdbuf    <= n_rdbuf;
                r_toggle   <= n_toggle;
                r_ctrl     <= n_ctrl;
                r_mask     <= n_mask;
                r_status   <= n_status;
                r_spr_addr <= n_spr_addr;
                r_dot      <= n_dot;
                r_line     <= n_line;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_word;
        end
        r_out_word <= n_out_word;
    end

endmodule

/* rtl/vurp_checker.sv */
// Port checker for the video unit register port, bound to the top level.
// Depends on vurp_pkg.
module vurp_checker
    import vurp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // Clearing pass blocks input right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    // Counters stay inside the frame
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.line_now <= 9'd261) && (o_out_word.dot_now <= 9'd340))
        else $error("counter out of range");

    // A fault comes only from the data port, an NMI never does
    a_nmi_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.nmi_pulse && o_out_word.access_fault))
        else $error("NMI and fault in one word");

endmodule

bind video_unit_register_port_top vurp_checker u_vurp_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_word(o_out_word)
);

/* bench/vurp_port_checker.sv */
// Port checker for the video unit register port: predicts each result word and compares it.
// Depends on vurp_pkg; watches the input, output and configuration channels of the block.
`timescale 1ns / 100ps

module vurp_port_checker
    import vurp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic      i_cfg_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results_seen,
    output int        o_nmi_seen,
    output int        o_fault_seen
);

    // Shadow state of the block
    logic [7:0]  nt_mem [NtDepth];
    logic [7:0]  pal_mem [PalDepth];
    logic [7:0]  spr_mem [SprDepth];
    logic [7:0]  pat_mem [PatDepth];
    logic [15:0] vaddr;
    logic [7:0]  rbuf;
    logic        wtoggle;
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  status_q;
    logic [7:0]  spaddr;
    logic [8:0]  scroll_x;
    logic [8:0]  scroll_y;
    logic [9:0]  dot_q;
    logic [8:0]  line_q;
    logic        mirror_q;

    t_out_word result_queue[$];

    function automatic logic [10:0] nt_slot(input logic [15:0] addr);
        logic [15:0] idx;
        logic [1:0]  tbl;
        idx = (addr & 16'h2FFF) - 16'h2000;
        tbl = idx[11:10];
        if (mirror_q) begin
            if (tbl >= 2) idx = idx - 16'h0800;
        end else begin
            if (tbl == 1 || tbl == 2) idx = idx - 16'h0400;
            else if (tbl == 3) idx = idx - 16'h0800;
        end
        return idx[10:0];
    endfunction

    function automatic logic [15:0] addr_step();
        return ctrl_q[2] ? 16'd32 : 16'd1;
    endfunction

    function automatic logic is_rendering();
        return (line_q < LineRender || line_q == LinePre) && (mask_q & 8'h18) != 0;
    endfunction

    function automatic logic advance_dots(input logic [7:0] dots);
        logic nmi;
        nmi = 1'b0;
        dot_q = dot_q + 10'(dots);
        if ((line_q == LinePre || line_q < LineVblank) && dot_q > 256 && dot_q < 321)
            spaddr = 8'd0;
        while (dot_q >= DotsPerLine) begin
            dot_q = dot_q - DotsPerLine;
            line_q = line_q + 9'd1;
            if (line_q == LineVblank) begin
                status_q[7] = 1'b1;
                if (ctrl_q[7]) begin
                    nmi = 1'b1;
                    dot_q = dot_q + 10'(NmiDots);
                end
            end
            if (line_q == LinePre) status_q[6] = 1'b0;
            if (line_q >= 262) begin
                line_q = 9'd0;
                status_q[7] = 1'b0;
            end
        end
        return nmi;
    endfunction

    // Apply one input word to the shadow state and return its expected result
    function automatic t_out_word predict_port_word(input t_in_word w);
        t_out_word r;
        r = '0;
        case (w.action)
            ACT_WRITE: begin
                case (w.register_index)
                    REG_CTRL: begin
                        if (!ctrl_q[7] && w.write_data[7] && status_q[7]) r.nmi_pulse = 1'b1;
                        ctrl_q = w.write_data;
                    end
                    REG_MASK:   mask_q = w.write_data;
                    REG_SPADDR: spaddr = w.write_data;
                    REG_SPDATA: begin
                        if (!is_rendering()) begin
                            spr_mem[spaddr] = w.write_data;
                            spaddr = spaddr + 8'd1;
                        end else begin
                            spaddr = spaddr + 8'd4;
                        end
                    end
                    REG_SCROLL: begin
                        if (!wtoggle) scroll_x = {ctrl_q[0], w.write_data};
                        else scroll_y = {ctrl_q[1], w.write_data};
                        wtoggle = ~wtoggle;
                    end
                    REG_ADDR: begin
                        if (!wtoggle) vaddr = {2'b00, w.write_data[5:0], 8'h00};
                        else vaddr = vaddr | {8'h00, w.write_data};
                        wtoggle = ~wtoggle;
                    end
                    REG_DATA: begin
                        if (vaddr < 16'h2000) r.access_fault = 1'b1;
                        else if (vaddr <= 16'h3EFF) nt_mem[nt_slot(vaddr)] = w.write_data;
                        else if (vaddr <= 16'h3FFF) pal_mem[vaddr[4:0]] = w.write_data;
                        vaddr = vaddr + addr_step();
                    end
                    default: ;
                endcase
            end
            ACT_READ: begin
                case (w.register_index)
                    REG_STATUS: begin
                        wtoggle = 1'b0;
                        r.read_data = status_q;
                        status_q[7] = 1'b0;
                    end
                    REG_SPDATA: r.read_data = spr_mem[spaddr];
                    REG_DATA: begin
                        r.read_data = rbuf;
                        if (vaddr <= 16'h1FFF) begin
                            rbuf = pat_mem[vaddr[12:0]];
                        end else if (vaddr <= 16'h3EFF) begin
                            rbuf = nt_mem[nt_slot(vaddr)];
                        end else if (vaddr <= 16'h3FFF) begin
                            r.read_data = pal_mem[vaddr[4:0]];
                            rbuf = nt_mem[nt_slot(vaddr - 16'h1000)];
                        end else begin
                            r.access_fault = 1'b1;
                        end
                        vaddr = vaddr + addr_step();
                    end
                    default: ;
                endcase
            end
            ACT_TICK:  r.nmi_pulse = advance_dots(w.dot_count);
            ACT_PLOAD: pat_mem[w.load_address] = w.write_data;
            ACT_DMA:   spr_mem[w.load_address[7:0]] = w.write_data;
            default: ;
        endcase
        r.line_now = line_q;
        r.dot_now = dot_q[8:0];
        return r;
    endfunction

    // Watch the channels at each rising edge
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            foreach (nt_mem[i]) nt_mem[i] = 8'h00;
            foreach (pal_mem[i]) pal_mem[i] = 8'h00;
            foreach (spr_mem[i]) spr_mem[i] = 8'h00;
            foreach (pat_mem[i]) pat_mem[i] = 8'h00;
            vaddr = '0; rbuf = '0; wtoggle = 1'b0; ctrl_q = '0; mask_q = '0;
            status_q = '0; spaddr = '0; scroll_x = '0; scroll_y = '0;
            dot_q = '0; line_q = '0; mirror_q = 1'b0;
            result_queue.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_nmi_seen <= 0;
            o_fault_seen <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) mirror_q = i_cfg_data;
            if (i_in_valid && !i_in_stall) result_queue.push_back(predict_port_word(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (i_out_word.nmi_pulse) o_nmi_seen <= o_nmi_seen + 1;
                if (i_out_word.access_fault) o_fault_seen <= o_fault_seen + 1;
                if (result_queue.size() == 0) begin
                    $error("result word with nothing expected: %p", i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = result_queue.pop_front();
                    if (exp_w != i_out_word) begin
                        o_fail_count <= o_fail_count + 1;
                        if (exp_w.read_data != i_out_word.read_data)
                            $error("read_data expected %0h got %0h",
                                   exp_w.read_data, i_out_word.read_data);
                        if (exp_w.nmi_pulse != i_out_word.nmi_pulse)
                            $error("nmi_pulse expected %0d got %0d",
                                   exp_w.nmi_pulse, i_out_word.nmi_pulse);
                        if (exp_w.access_fault != i_out_word.access_fault)
                            $error("access_fault expected %0d got %0d",
                                   exp_w.access_fault, i_out_word.access_fault);
                        if (exp_w.line_now != i_out_word.line_now)
                            $error("line_now expected %0d got %0d",
                                   exp_w.line_now, i_out_word.line_now);
                        if (exp_w.dot_now != i_out_word.dot_now)
                            $error("dot_now expected %0d got %0d",
                                   exp_w.dot_now, i_out_word.dot_now);
                    end
                end
            end
        end
        o_pending <= result_queue.size();
    end

endmodule

/* bench/tb_video_unit_register_port_top.sv */
// Testbench top for the video unit register port: clock, reset, stimulus and verdict.
// Depends on vurp_pkg, the block and vurp_port_checker.
`timescale 1ns / 100ps

module tb_video_unit_register_port_top;
    import vurp_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    int        fail_count;
    int        pending;
    int        results_seen;
    int        nmi_seen;
    int        fault_seen;
    int        words_sent;
    bit        stall_free;

    // Pattern addresses that have been loaded; data reads below 0x2000 stay on these
    bit        pat_loaded [PatDepth];

    video_unit_register_port_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    vurp_port_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_word      (in_word),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_word     (out_word),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_nmi_seen     (nmi_seen),
        .o_fault_seen   (fault_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall pattern: phases of heavy, light or no stalling
    initial begin
        int mode;
        out_stall = 1'b0;
        mode = 0;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            if (stall_free || mode == 0) out_stall <= 1'b0;
            else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
            else out_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Shadow of the data-port address, for keeping pattern reads on loaded entries
    logic [15:0] tb_vaddr;
    logic        tb_toggle;
    logic [7:0]  tb_ctrl;

    task automatic send_word(input t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        in_valid <= 1'b0;
        // the block is busy on the edge after an accept anyway
        @(posedge clk);
        words_sent++;
        // track address side effects
        if (w.action == ACT_PLOAD) pat_loaded[w.load_address] = 1'b1;
        if (w.action == ACT_WRITE && w.register_index == REG_CTRL) tb_ctrl = w.write_data;
        if (w.action == ACT_READ && w.register_index == REG_STATUS) tb_toggle = 1'b0;
        if (w.action == ACT_WRITE && w.register_index == REG_SCROLL) tb_toggle = ~tb_toggle;
        if (w.action == ACT_WRITE && w.register_index == REG_ADDR) begin
            if (!tb_toggle) tb_vaddr = {2'b00, w.write_data[5:0], 8'h00};
            else tb_vaddr = tb_vaddr | {8'h00, w.write_data};
            tb_toggle = ~tb_toggle;
        end
        if ((w.action == ACT_WRITE || w.action == ACT_READ) && w.register_index == REG_DATA)
            tb_vaddr = tb_vaddr + (tb_ctrl[2] ? 16'd32 : 16'd1);
    endtask

    function automatic t_in_word make_word(input logic [2:0] act, input logic [2:0] ridx,
                                           input logic [7:0] d);
        t_in_word w;
        w.action = act;
        w.register_index = ridx;
        w.write_data = d;
        w.dot_count = 8'($urandom);
        w.load_address = 13'($urandom);
        return w;
    endfunction

    task automatic wait_idle();
        int guard;
        guard = 0;
        @(posedge clk);
        while ((pending != 0 || in_valid) && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mirroring(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Two writes to the address register, resetting the toggle first
    task automatic set_vaddr(input logic [13:0] a);
        send_word(make_word(ACT_READ, REG_STATUS, 8'h00));
        send_word(make_word(ACT_WRITE, REG_ADDR, {2'b00, a[13:8]}));
        send_word(make_word(ACT_WRITE, REG_ADDR, a[7:0]));
    endtask

    // Full-length ticks to walk the counters through a frame
    task automatic send_long_ticks(input int count);
        t_in_word w;
        for (int i = 0; i < count; i++) begin
            w = make_word(ACT_TICK, REG_CTRL, 8'h00);
            w.dot_count = 8'hFF;
            send_word(w);
        end
    endtask

    // One random word or address setup, weighted toward well-formed register traffic
    task automatic send_random_word();
        t_in_word w;
        int pick;
        pick = $urandom_range(0, 99);
        w = make_word(3'($urandom_range(0, 4)), 3'($urandom), 8'($urandom));
        if (pick < 10) begin
            set_vaddr(14'($urandom_range(16'h2000, 16'h3FFF)));
            return;
        end else if (pick < 14) begin
            w = make_word(ACT_WRITE, REG_ADDR, 8'($urandom));
        end else if (pick < 20) begin
            w.action = ACT_PLOAD;
            w.load_address = 13'($urandom_range(0, 63));
        end else if (pick < 40) begin
            w.register_index = REG_DATA;
            w.action = ($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE;
        end else if (pick < 48) begin
            w.action = 3'($urandom_range(5, 7));
        end else if (pick < 62) begin
            w.action = ACT_TICK;
        end
        // a data read below 0x2000 must hit a loaded pattern entry
        if (w.action == ACT_READ && w.register_index == REG_DATA && tb_vaddr <= 16'h1FFF
            && !pat_loaded[tb_vaddr[12:0]]) begin
            w.action = ACT_PLOAD;
            w.load_address = tb_vaddr[12:0];
        end
        send_word(w);
    endtask

    initial begin
        int k;
        int burst;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        stall_free = 1'b0;
        words_sent = 0;
        tb_vaddr   = '0;
        tb_toggle  = 1'b0;
        tb_ctrl    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every register, faults, palette read, high-address read
        write_mirroring(1'b1);
        send_word(make_word(ACT_WRITE, REG_DATA, 8'hFF));
        send_word(make_word(ACT_PLOAD, REG_CTRL, 8'hA5));
        send_word(make_word(ACT_WRITE, REG_CTRL, 8'h07));
        send_word(make_word(ACT_WRITE, REG_SCROLL, 8'hFF));
        send_word(make_word(ACT_WRITE, REG_SCROLL, 8'h00));
        set_vaddr(14'h3F1F);
        send_word(make_word(ACT_WRITE, REG_DATA, 8'h5A));
        set_vaddr(14'h3F1F);
        send_word(make_word(ACT_READ, REG_DATA, 8'h00));
        send_word(make_word(ACT_WRITE, REG_ADDR, 8'hFF));
        send_word(make_word(ACT_WRITE, REG_ADDR, 8'hFF));
        send_word(make_word(ACT_READ, REG_DATA, 8'h00));
        send_word(make_word(ACT_WRITE, REG_CTRL, 8'h00));
        for (k = 0; k < 8; k++) send_word(make_word(ACT_READ, 3'(k), 8'h00));
        send_word(make_word(ACT_WRITE, REG_STATUS, 8'hFF));
        send_word(make_word(ACT_WRITE, REG_MASK, 8'h18));
        send_word(make_word(ACT_WRITE, REG_SPDATA, 8'h33));
        send_word(make_word(ACT_DMA, REG_CTRL, 8'h00));
        send_word(make_word(3'd7, REG_DATA, 8'hFF));

        // Directed: NMI at vblank, NMI on the enable edge inside vblank, frame wrap
        send_word(make_word(ACT_WRITE, REG_CTRL, 8'h80));
        send_long_ticks(330);
        send_word(make_word(ACT_WRITE, REG_CTRL, 8'h00));
        send_word(make_word(ACT_WRITE, REG_CTRL, 8'h80));
        send_long_ticks(30);
        wait_idle();
        write_mirroring(1'b0);

        // Random phases, mirroring changing between them
        for (int ph = 0; ph < 5; ph++) begin
            stall_free = (ph == 2);
            for (int n = 0; n < 140; ) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 140; b++, n++) send_random_word();
                if ($urandom_range(0, 1) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            // drain fully before changing mirroring
            wait_idle();
            write_mirroring(1'($urandom_range(0, 1)));
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Sent %0d words, checked %0d results (%0d NMI, %0d faults).",
                 words_sent, results_seen, nmi_seen, fault_seen);
        $display("Covered all registers, ticks through vblank, both mirroring modes.");
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
